// ----- rtl/ssls_pkg.sv -----
// ============================================================================
// ssls_pkg: shared definitions for the seven-segment scan controller
// Operation codes, register indexes and the command and status bundles
// that join the controller to the datapath.
// ============================================================================
`default_nettype none

package ssls_pkg;

    // Operation codes carried in the operation field of an item.
    localparam logic [2:0] OP_CHAR    = 3'd0;
    localparam logic [2:0] OP_IND     = 3'd1;
    localparam logic [2:0] OP_DOT     = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_REFRESH = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    // Configuration register indexes.
    localparam int          CFG_IW    = 2;
    localparam int          CFG_DW    = 2;
    localparam logic [1:0]  CFG_SLEEP = 2'd0;
    localparam logic [1:0]  CFG_EDIT  = 2'd1;
    localparam logic [1:0]  CFG_SHOW  = 2'd2;

    // Image layout: eight bytes per page, byte six holds the indicators.
    localparam int         IMG_BYTES = 8;
    localparam logic [2:0] IND_BYTE  = 3'd6;
    localparam logic [2:0] LAST_SEG  = 3'd6;

    typedef struct packed {
        logic       char_wr;
        logic       clear_all;
        logic       tick;
        logic       rd_en;
        logic       rd_show;
        logic [2:0] addr;
        logic       ind_wr;
        logic       dot_wr;
        logic       col_ld;
        logic       sleep_ld;
    } t_cmd;

    typedef struct packed {
        logic sleep;
        logic out_stall;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/ssls_ifs.sv -----
// ============================================================================
// ssls channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ============================================================================
`default_nettype none

interface ssls_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [2:0] position;
    logic [7:0] char_code;
    logic [5:0] indicator_number;
    logic       switch_on;
    logic       thousands_mark;

    modport source (
        output valid, operation, position, char_code, indicator_number,
               switch_on, thousands_mark,
        input  ready
    );
    modport sink (
        input  valid, operation, position, char_code, indicator_number,
               switch_on, thousands_mark,
        output ready
    );
endinterface

interface ssls_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_select;
    logic [6:0] segment_data;

    modport source (output valid, digit_select, segment_data, input ready);
    modport sink   (input valid, digit_select, segment_data, output ready);
endinterface

interface ssls_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ssls_pkg::CFG_IW-1:0]  index;
    logic [ssls_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssls_ctrl.sv -----
// ============================================================================
// ssls_ctrl: operation sequencer
// Accepts items and steps the datapath through the image memory sweeps.
// ============================================================================
`default_nettype none

module ssls_ctrl #(
    parameter int DIGITS = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_op,
    input  wire logic [2:0]        i_pos,
    input  wire ssls_pkg::t_status i_status,
    output logic                   o_ready,
    output ssls_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_IND_RD,
        S_IND_WR,
        S_DOT_RD,
        S_DOT_WR,
        S_RF_RD,
        S_RF_COL,
        S_SL_RD,
        S_SL_WR
    } t_state;

    localparam logic [3:0] DIG_W    = 4'(DIGITS);
    localparam logic [2:0] DOT_LAST = 3'(DIGITS - 1);

    t_state     r_state;
    logic [2:0] r_idx;
    logic       accept;
    logic       pos_ok;

    assign pos_ok  = ({1'b0, i_pos} < DIG_W);
    assign o_ready = (r_state == S_IDLE) &&
                     !((i_op == ssls_pkg::OP_TICK) && i_status.out_stall);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 3'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= 3'd0;
                    if (accept) begin
                        case (i_op)
                            ssls_pkg::OP_IND: r_state <= S_IND_RD;
                            ssls_pkg::OP_DOT: begin
                                if (!i_status.sleep && pos_ok) begin
                                    r_state <= S_DOT_RD;
                                end
                            end
                            ssls_pkg::OP_REFRESH: begin
                                r_state <= i_status.sleep ? S_SL_RD : S_RF_RD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_IND_RD: r_state <= S_IND_WR;
                S_IND_WR: r_state <= S_IDLE;
                S_DOT_RD: r_state <= S_DOT_WR;
                S_DOT_WR: begin
                    if (r_idx == DOT_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_DOT_RD;
                    end
                end
                S_RF_RD: r_state <= S_RF_COL;
                S_RF_COL: begin
                    if (r_idx == ssls_pkg::LAST_SEG) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_RF_RD;
                    end
                end
                S_SL_RD: r_state <= S_SL_WR;
                S_SL_WR: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.char_wr   = accept && (i_op == ssls_pkg::OP_CHAR) && pos_ok;
        o_cmd.clear_all = accept && (i_op == ssls_pkg::OP_CLEAR);
        o_cmd.tick      = accept && (i_op == ssls_pkg::OP_TICK);
        o_cmd.rd_en     = (r_state == S_IND_RD) || (r_state == S_DOT_RD) ||
                          (r_state == S_RF_RD)  || (r_state == S_SL_RD);
        o_cmd.rd_show   = (r_state == S_RF_RD) || (r_state == S_SL_RD);
        o_cmd.ind_wr    = (r_state == S_IND_WR);
        o_cmd.dot_wr    = (r_state == S_DOT_WR);
        o_cmd.col_ld    = (r_state == S_RF_COL);
        o_cmd.sleep_ld  = (r_state == S_SL_WR);
        if ((r_state == S_IND_RD) || (r_state == S_IND_WR) || (r_state == S_SL_RD)) begin
            o_cmd.addr = ssls_pkg::IND_BYTE;
        end else begin
            o_cmd.addr = r_idx;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssls_dp.sv -----
// ============================================================================
// ssls_dp: image memory, scan store and result register
// Holds the configuration registers, the paged image memory with its
// valid bits, the scan store and the output register.
// ============================================================================
`default_nettype none

module ssls_dp #(
    parameter int PAGES  = 4,
    parameter int DIGITS = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssls_pkg::t_cmd              i_cmd,
    input  wire logic                        i_accept,
    input  wire logic [2:0]                  i_pos,
    input  wire logic [7:0]                  i_code,
    input  wire logic [5:0]                  i_num,
    input  wire logic                        i_on,
    input  wire logic                        i_thou,
    input  wire logic                        i_cfg_wr,
    input  wire logic [ssls_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [ssls_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                        i_out_ready,
    output ssls_pkg::t_status                o_status,
    output logic                             o_out_valid,
    output logic [7:0]                       o_digit_select,
    output logic [6:0]                       o_segment_data
);

    localparam int         DEPTH   = PAGES * ssls_pkg::IMG_BYTES;
    localparam int         AW      = $clog2(DEPTH);
    localparam logic [3:0] PAGES_W = 4'(PAGES);
    localparam logic [3:0] DIG_W   = 4'(DIGITS);

    localparam logic [7:0] FONT_ROM [64] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h27,
        8'h7f, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h6f,
        8'h76, 8'h04, 8'h1e, 8'h70, 8'h38, 8'h55, 8'h54, 8'h5c,
        8'h73, 8'h67, 8'h50, 8'h6d, 8'h78, 8'h3e, 8'h1c, 8'h1d,
        8'h49, 8'h6e, 8'h5b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
    };

    // Lower case folds to upper case, anything outside space..underscore
    // shows as a space.
    function automatic logic [7:0] char_font(input logic [7:0] code);
        logic [7:0] c;
        logic [7:0] idx;
        c = code;
        if ((c >= 8'h61) && (c <= 8'h7a)) begin
            c = c - 8'h20;
        end
        if ((c < 8'h20) || (c > 8'h5f)) begin
            c = 8'h20;
        end
        idx = c - 8'h20;
        return FONT_ROM[idx[5:0]];
    endfunction

    // Indicator bit within image byte six. Numbers above 34, like every
    // number not listed, map to no bit.
    function automatic logic [7:0] ind_mask(input logic [5:0] num);
        logic [7:0] m;
        case (num)
            6'd4:    m = 8'h01;
            6'd5:    m = 8'h02;
            6'd6:    m = 8'h04;
            6'd7:    m = 8'h08;
            6'd12:   m = 8'h80;
            6'd14:   m = 8'h20;
            6'd15:   m = 8'h40;
            6'd29:   m = 8'h10;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [1:0] page,
                                               input logic [2:0] byte_no);
        logic [7:0] ext;
        ext = {3'b000, page, byte_no};
        return ext[AW-1:0];
    endfunction

    logic             r_sleep;
    logic [1:0]       r_edit;
    logic [1:0]       r_show;
    logic [2:0]       r_pos;
    logic [5:0]       r_num;
    logic             r_on;
    logic             r_thou;
    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;
    logic [6:0]       r_scan [8];
    logic [2:0]       r_cnt;
    logic             r_out_valid;
    logic [7:0]       r_sel;
    logic [6:0]       r_seg;

    logic            edit_ok;
    logic            show_ok;
    logic            rd_ok;
    logic [1:0]      rd_page;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [2:0]      wr_byte;
    logic [7:0]      wr_data;
    logic            wr_en;
    logic [7:0]      rd_byte;
    logic [7:0]      mask;
    logic            dot_on;
    logic [3:0]      b4;
    logic [3:0]      p4;

    assign edit_ok = ({2'b00, r_edit} < PAGES_W);
    assign show_ok = ({2'b00, r_show} < PAGES_W);
    assign rd_page = i_cmd.rd_show ? r_show : r_edit;
    assign rd_ok   = i_cmd.rd_show ? show_ok : edit_ok;
    assign rd_addr = mem_addr(rd_page, i_cmd.addr);
    assign rd_byte = r_rd_vld ? r_rd_data : 8'h00;
    assign mask    = ind_mask(r_num);

    // Dot of byte b is lit for the decimal point at DIGITS-1-pos and for the
    // thousands mark three places higher, at DIGITS-4-pos.
    assign b4     = {1'b0, i_cmd.addr};
    assign p4     = {1'b0, r_pos};
    assign dot_on = ((r_pos != 3'd0) && ((b4 + p4 + 4'd1) == DIG_W)) ||
                    (r_thou && ((p4 + 4'd3) < DIG_W) && ((b4 + p4 + 4'd4) == DIG_W));

    always_comb begin
        wr_byte = i_cmd.addr;
        wr_data = rd_byte;
        if (i_cmd.char_wr) begin
            wr_byte = i_pos;
            wr_data = char_font(i_code);
        end else if (i_cmd.ind_wr) begin
            wr_data = r_on ? (rd_byte | mask) : (rd_byte & ~mask);
        end else begin
            wr_data = {dot_on, rd_byte[6:0]};
        end
    end

    assign wr_en   = (i_cmd.char_wr || i_cmd.ind_wr || i_cmd.dot_wr) && edit_ok;
    assign wr_addr = mem_addr(r_edit, wr_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep <= 1'b0;
            r_edit  <= 2'd0;
            r_show  <= 2'd0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                ssls_pkg::CFG_SLEEP: r_sleep <= i_cfg_data[0];
                ssls_pkg::CFG_EDIT:  r_edit  <= i_cfg_data[1:0];
                ssls_pkg::CFG_SHOW:  r_show  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pos  <= i_pos;
            r_num  <= i_num;
            r_on   <= i_on;
            r_thou <= i_thou;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= rd_ok && r_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < 8; l++) begin
                r_scan[l] <= 7'h00;
            end
        end else if (i_cmd.col_ld) begin
            for (int l = 0; l < 8; l++) begin
                r_scan[l][i_cmd.addr] <= rd_byte[l];
            end
        end else if (i_cmd.sleep_ld) begin
            for (int l = 0; l < 8; l++) begin
                if ((l == 4) && rd_byte[4]) begin
                    r_scan[l] <= 7'h60;
                end else begin
                    r_scan[l] <= (l < 6) ? 7'h20 : 7'h00;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                r_out_valid <= 1'b1;
                r_cnt       <= r_cnt + 3'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_sel <= 8'b0000_0001 << r_cnt;
            r_seg <= r_scan[r_cnt];
        end
    end

    assign o_status.sleep     = r_sleep;
    assign o_status.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_digit_select     = r_sel;
    assign o_segment_data     = r_seg;

endmodule

`default_nettype wire

// ----- rtl/seven_segment_led_scan_controller.sv -----
// ============================================================================
// seven_segment_led_scan_controller: paged seven-segment display scanner
// Keeps paged segment images, transposes the shown page into a scan store
// and drives one one-hot scan line with its segments per tick item.
// ============================================================================
//
// Channel   Direction  Payload
// i_item    in         operation, position, char_code, indicator_number,
//                      switch_on, thousands_mark
// o_result  out        digit_select, segment_data (tick items only)
// i_cfg     in         index, data (0 sleep_mode, 1 edit_page, 2 show_page)
//
// Character, clear and tick items finish when they are accepted; register
// writes are always taken. An indicator item reads and rewrites byte six,
// a decimal point item (unless it is ignored) reads and rewrites each of
// the DIGITS bytes, and a refresh reads bytes 0..6 (only byte six while
// sleeping). These steps come from the single read port of the image
// memory: each byte is read in one state and used or rewritten in the next.
// Reset is synchronous and active low; it clears the registers, the
// image valid bits, the scan store and the scan counter at once.
// A tick item waits while the previous result is still held by o_result;
// all other items pass a waiting result.
//
// The image is a memory with one valid bit per byte. Clearing all pages
// drops the valid bits, and a byte whose valid bit is low reads as zero.
// A character item writes its byte in the cycle it is accepted; indicator
// and decimal point items update the image as a read-modify-write through
// the datapath, sequenced by the controller.
// ============================================================================
`default_nettype none

module seven_segment_led_scan_controller #(
    parameter int PAGES  = 4,
    parameter int DIGITS = 6
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ssls_item_if.sink     i_item,
    ssls_result_if.source o_result,
    ssls_cfg_if.sink      i_cfg
);

    ssls_pkg::t_cmd    cmd;
    ssls_pkg::t_status status;
    logic              item_ready;

    assign i_item.ready = item_ready;
    assign i_cfg.ready  = 1'b1;

    ssls_ctrl #(
        .DIGITS (DIGITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_op     (i_item.operation),
        .i_pos    (i_item.position),
        .i_status (status),
        .o_ready  (item_ready),
        .o_cmd    (cmd)
    );

    ssls_dp #(
        .PAGES  (PAGES),
        .DIGITS (DIGITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_accept       (i_item.valid && item_ready),
        .i_pos          (i_item.position),
        .i_code         (i_item.char_code),
        .i_num          (i_item.indicator_number),
        .i_on           (i_item.switch_on),
        .i_thou         (i_item.thousands_mark),
        .i_cfg_wr       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_result.ready),
        .o_status       (status),
        .o_out_valid    (o_result.valid),
        .o_digit_select (o_result.digit_select),
        .o_segment_data (o_result.segment_data)
    );

endmodule

`default_nettype wire

// ----- rtl/ssls_checker.sv -----
// ============================================================================
// ssls_checker: port-level checks for the scan controller
// Watches the item and result channels and checks how results follow ticks.
// ============================================================================
`default_nettype none

module ssls_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [2:0] i_in_op,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_sel,
    input wire logic [6:0] i_out_seg
);

    logic tick_acc;

    assign tick_acc = i_in_valid && i_in_ready && (i_in_op == ssls_pkg::OP_TICK);

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot(i_out_sel))
        else $error("digit select is not one-hot");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(tick_acc))
        else $error("result appeared without a tick item");

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> i_out_valid)
        else $error("tick item gave no result");

    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && i_in_valid && (i_in_op == ssls_pkg::OP_TICK))
        |-> !i_in_ready)
        else $error("tick item taken while a result waits");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_sel) && $stable(i_out_seg)))
        else $error("stalled result changed");

endmodule

bind seven_segment_led_scan_controller ssls_checker u_ssls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.operation),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_sel   (o_result.digit_select),
    .i_out_seg   (o_result.segment_data)
);

`default_nettype wire

// ----- tb/seven_segment_led_scan_controller_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// seven_segment_led_scan_controller_test: self-checking scan controller bench
// Drives character, indicator, dot, clear, refresh and tick items through
// several register settings, predicts every scan line and compares it with
// the block's result channel under random idling on both sides.
// ============================================================================

module seven_segment_led_scan_controller_test;

    // Block geometry, matched to the instance below.
    localparam int PAGE_COUNT  = 4;
    localparam int DIGIT_COUNT = 6;
    localparam int IND_LAST    = 34;

    // Operation codes the block accepts but ignores.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Run shape.
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 24;    // longest item (refresh) plus margin
    localparam int QUIET_LIMIT     = 2000;  // cycles without any handshake
    localparam int REPORT_LIMIT    = 10;

    // Font for codes 0x20..0x5F, indexed by code - 0x20.
    localparam logic [0:63][7:0] GLYPHS = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h27,
        8'h7f, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h6f,
        8'h76, 8'h04, 8'h1e, 8'h70, 8'h38, 8'h55, 8'h54, 8'h5c,
        8'h73, 8'h67, 8'h50, 8'h6d, 8'h78, 8'h3e, 8'h1c, 8'h1d,
        8'h49, 8'h6e, 8'h5b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
    };

    // Bit of image byte six owned by each indicator number; zero means the
    // indicator does not exist and the item leaves the image alone.
    localparam logic [0:34][7:0] IND_MASKS = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h20, 8'h40,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00
    };

    // Indicator numbers that actually map to a bit, used to bias stimulus.
    localparam logic [0:7][5:0] USED_INDICATORS = {
        6'd4, 6'd5, 6'd6, 6'd7, 6'd12, 6'd14, 6'd15, 6'd29
    };

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] pos;
        logic [7:0] code;
        logic [5:0] num;
        logic       on;
        logic       thou;
    } t_scan_item;

    typedef struct packed {
        logic [7:0] sel;
        logic [6:0] seg;
    } t_scan_line;

    // ------------------------------------------------------------------------
    // Predictor: a private copy of the image pages, the scan store, the scan
    // pointer and the registers, plus the queue of scan lines that accepted
    // tick items still owe.
    // ------------------------------------------------------------------------
    class led_scan_predictor;
        logic [7:0] image [PAGE_COUNT][8];
        logic [7:0] scan_lines [8];
        logic [2:0] line_ptr;
        logic       sleeping;
        logic [1:0] edit_pg;
        logic [1:0] show_pg;
        t_scan_line pending_lines[$];
        int         mismatches;
        int         lines_checked;

        function new();
            foreach (image[pg, b]) image[pg][b] = 8'h00;
            foreach (scan_lines[l]) scan_lines[l] = 8'h00;
            line_ptr      = 3'd0;
            sleeping      = 1'b0;
            edit_pg       = 2'd0;
            show_pg       = 2'd0;
            mismatches    = 0;
            lines_checked = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [1:0] value);
            case (idx)
                ssls_pkg::CFG_SLEEP: sleeping = value[0];
                ssls_pkg::CFG_EDIT:  edit_pg  = value;
                ssls_pkg::CFG_SHOW:  show_pg  = value;
                default: ;
            endcase
        endfunction

        // Note one accepted item and advance the predicted state.
        function void note_item(t_scan_item it);
            logic [7:0] ch;
            logic [5:0] n;
            logic [7:0] v;
            t_scan_line e;
            int         p;
            case (it.op)
                ssls_pkg::OP_CHAR: begin
                    if (it.pos < DIGIT_COUNT && edit_pg < PAGE_COUNT) begin
                        ch = it.code;
                        if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
                        if (ch < 8'h20 || ch > 8'h5f) ch = 8'h20;
                        ch = ch - 8'h20;
                        image[edit_pg][it.pos] = GLYPHS[ch[5:0]];
                    end
                end
                ssls_pkg::OP_IND: begin
                    n = (it.num > IND_LAST) ? 6'(IND_LAST) : it.num;
                    if (it.on) image[edit_pg][ssls_pkg::IND_BYTE] |= IND_MASKS[n];
                    else       image[edit_pg][ssls_pkg::IND_BYTE] &= ~IND_MASKS[n];
                end
                ssls_pkg::OP_DOT: begin
                    p = it.pos;
                    if (!sleeping && p < DIGIT_COUNT) begin
                        for (int i = 0; i < DIGIT_COUNT; i++)
                            image[edit_pg][i][7] = 1'b0;
                        if (p != 0) image[edit_pg][DIGIT_COUNT - 1 - p][7] = 1'b1;
                        if (it.thou && p + 3 < DIGIT_COUNT)
                            image[edit_pg][DIGIT_COUNT - 4 - p][7] = 1'b1;
                    end
                end
                ssls_pkg::OP_CLEAR: begin
                    foreach (image[pg, b]) image[pg][b] = 8'h00;
                end
                ssls_pkg::OP_REFRESH: begin
                    if (sleeping) begin
                        foreach (scan_lines[l]) scan_lines[l] = (l < 6) ? 8'h20 : 8'h00;
                        if (image[show_pg][ssls_pkg::IND_BYTE][4]) scan_lines[4] |= 8'h40;
                    end else begin
                        for (int l = 0; l < 8; l++) begin
                            v = 8'h00;
                            for (int k = 0; k < 7; k++) v[k] = image[show_pg][k][l];
                            scan_lines[l] = v;
                        end
                    end
                end
                ssls_pkg::OP_TICK: begin
                    e.sel = 8'd1 << line_ptr;
                    e.seg = scan_lines[line_ptr][6:0];
                    pending_lines.push_back(e);
                    line_ptr = line_ptr + 3'd1;
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted scan line with the oldest owed one.
        function void check_line(logic [7:0] sel, logic [6:0] seg);
            t_scan_line e;
            if (pending_lines.size() == 0) begin
                flag($sformatf("unexpected scan line sel=%02h seg=%02h", sel, seg));
                return;
            end
            e = pending_lines.pop_front();
            lines_checked++;
            if (e.sel !== sel)
                flag($sformatf("line %0d digit_select: expected %02h, got %02h",
                               lines_checked, e.sel, sel));
            if (e.seg !== seg)
                flag($sformatf("line %0d segment_data: expected %02h, got %02h",
                               lines_checked, e.seg, seg));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block.
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    bit   idle_on;
    int   items_sent;
    int   ticks_sent;
    int   spare_sent;
    int   quiet;

    led_scan_predictor pred = new();
    t_scan_item        seen_item;

    ssls_item_if   item_ch ();
    ssls_result_if res_ch ();
    ssls_cfg_if    cfg_ch ();

    seven_segment_led_scan_controller #(
        .PAGES  (PAGE_COUNT),
        .DIGITS (DIGIT_COUNT)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the block's
    // own updates land. A result taken at an edge always belongs to an
    // earlier tick item, so it is checked before the item of the same edge
    // is applied to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready)
                pred.check_line(res_ch.digit_select, res_ch.segment_data);
            if (item_ch.valid && item_ch.ready) begin
                seen_item.op   = item_ch.operation;
                seen_item.pos  = item_ch.position;
                seen_item.code = item_ch.char_code;
                seen_item.num  = item_ch.indicator_number;
                seen_item.on   = item_ch.switch_on;
                seen_item.thou = item_ch.thousands_mark;
                pred.note_item(seen_item);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                pred.set_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles, %0d scan lines still owed",
                         QUIET_LIMIT, pred.pending_lines.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: ready drops for random bursts while idling is enabled,
    // and stays high otherwise.
    initial begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 15) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item source. Valid is left high after an item is taken; the next call
    // either keeps it high with new fields or drops it for a gap first, so
    // valid never gets two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_scan_item it);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.operation        <= it.op;
        item_ch.position         <= it.pos;
        item_ch.char_code        <= it.code;
        item_ch.indicator_number <= it.num;
        item_ch.switch_on        <= it.on;
        item_ch.thousands_mark   <= it.thou;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        if (it.op > ssls_pkg::OP_TICK) spare_sent++;
        else items_sent++;
        if (it.op == ssls_pkg::OP_TICK) ticks_sent++;
    endtask

    // Writes all three registers back to back with valid held high.
    task automatic write_regs(input logic sleep, input logic [1:0] edit,
                              input logic [1:0] show);
        logic [1:0] idx [3];
        logic [1:0] val [3];
        idx = '{ssls_pkg::CFG_SLEEP, ssls_pkg::CFG_EDIT, ssls_pkg::CFG_SHOW};
        val = '{{1'b0, sleep}, edit, show};
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: every owed scan line must arrive, then the block gets time to
    // finish a refresh or dot update that produces no result.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pred.pending_lines.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_scan_item make_item(logic [2:0] op, logic [2:0] pos,
                                             logic [7:0] code, logic [5:0] num,
                                             logic on, logic thou);
        t_scan_item it;
        it.op   = op;
        it.pos  = pos;
        it.code = code;
        it.num  = num;
        it.on   = on;
        it.thou = thou;
        return it;
    endfunction

    // Random fields for one operation. Positions are mostly in range, codes
    // lean toward the printable font, indicators toward those that exist.
    function automatic t_scan_item random_item(logic [2:0] op);
        t_scan_item it;
        it.op   = op;
        it.pos  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
        it.code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h20, 8'h7f))
                                              : 8'($urandom);
        it.num  = ($urandom_range(0, 1) == 0) ? USED_INDICATORS[$urandom_range(0, 7)]
                                              : 6'($urandom);
        it.on   = 1'($urandom);
        it.thou = 1'($urandom);
        return it;
    endfunction

    // One display frame: an optional clear, a few edits, a refresh and a run of
    // ticks. A small share of frames is pure noise or skips the refresh.
    task automatic random_frame();
        int         writes;
        logic [2:0] op;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_item(random_item(3'($urandom_range(0, 7))));
            return;
        end
        if ($urandom_range(0, 7) == 0) send_item(random_item(ssls_pkg::OP_CLEAR));
        writes = $urandom_range(1, 8);
        for (int i = 0; i < writes; i++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: op = ssls_pkg::OP_CHAR;
                3, 4:    op = ssls_pkg::OP_IND;
                default: op = ssls_pkg::OP_DOT;
            endcase
            send_item(random_item(op));
        end
        if ($urandom_range(0, 9) != 0) send_item(random_item(ssls_pkg::OP_REFRESH));
        repeat ($urandom_range(1, 10)) send_item(random_item(ssls_pkg::OP_TICK));
    endtask

    // Directed items: case folding, codes outside the font, out-of-range
    // positions, the indicator clamp and empty indicators, thousands-mark
    // dots at positions 2, 0 and 7, ignored codes, an eight-line scan, a clear.
    task automatic run_directed();
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd0, 8'h61, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd5, 8'h7a, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd1, 8'h00, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd2, 8'hff, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd3, 8'h5f, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd6, 8'h41, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CHAR, 3'd7, 8'h60, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_IND, 3'd0, 8'h00, 6'd4, 1'b1, 1'b0));
        send_item(make_item(ssls_pkg::OP_IND, 3'd0, 8'h00, 6'd29, 1'b1, 1'b0));
        send_item(make_item(ssls_pkg::OP_IND, 3'd0, 8'h00, 6'd63, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_IND, 3'd0, 8'h00, 6'd0, 1'b1, 1'b0));
        send_item(make_item(ssls_pkg::OP_DOT, 3'd2, 8'h00, 6'd0, 1'b0, 1'b1));
        send_item(make_item(ssls_pkg::OP_DOT, 3'd0, 8'h00, 6'd0, 1'b0, 1'b1));
        send_item(make_item(ssls_pkg::OP_DOT, 3'd7, 8'h00, 6'd0, 1'b0, 1'b1));
        send_item(make_item(OP_SPARE_LO, 3'd0, 8'h00, 6'd0, 1'b0, 1'b0));
        send_item(make_item(OP_SPARE_HI, 3'd7, 8'hff, 6'h3f, 1'b1, 1'b1));
        send_item(make_item(ssls_pkg::OP_REFRESH, 3'd0, 8'h00, 6'd0, 1'b0, 1'b0));
        repeat (8) send_item(make_item(ssls_pkg::OP_TICK, 3'd0, 8'h00, 6'd0, 1'b0, 1'b0));
        send_item(make_item(ssls_pkg::OP_CLEAR, 3'd0, 8'h00, 6'd0, 1'b0, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. After the directed part, each phase writes a new
    // register setting (sleep on in three phases, edit and show pages both
    // swept through 0..3 and paired in several ways), runs random frames and
    // drains. Some phases run without idling, and the last two have none.
    // ------------------------------------------------------------------------
    initial begin
        int         start;
        logic       sleep;
        logic [1:0] edit;
        logic [1:0] show;

        rst_n                    <= 1'b0;
        idle_on                   = 1'b0;
        items_sent                = 0;
        ticks_sent                = 0;
        spare_sent                = 0;
        quiet                     = 0;
        item_ch.valid            <= 1'b0;
        item_ch.operation        <= ssls_pkg::OP_CHAR;
        item_ch.position         <= 3'd0;
        item_ch.char_code        <= 8'h00;
        item_ch.indicator_number <= 6'd0;
        item_ch.switch_on        <= 1'b0;
        item_ch.thousands_mark   <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= ssls_pkg::CFG_SLEEP;
        cfg_ch.data              <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_regs(1'b0, 2'd0, 2'd0);
        idle_on = 1'b1;
        run_directed();
        settle();

        for (int p = 0; p < PHASES; p++) begin
            sleep = (p == 2 || p == 5 || p == 8);
            edit  = 2'(p);
            show  = 2'(p + p / 4);
            write_regs(sleep, edit, show);
            idle_on = (p < PHASES - 2) && (p % 3 != 1);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) random_frame();
            settle();
        end

        $display("Covered %0d items (%0d scan ticks, %0d ignored codes) over %0d settings.",
                 items_sent, ticks_sent, spare_sent, PHASES + 1);
        $display("Scan lines checked: %0d, mismatches: %0d.",
                 pred.lines_checked, pred.mismatches);
        if (pred.pending_lines.size() != 0)
            $display("ERROR: %0d scan lines never arrived", pred.pending_lines.size());
        if (pred.mismatches == 0 && pred.pending_lines.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssls_pkg.sv
rtl/ssls_ifs.sv
rtl/ssls_ctrl.sv
rtl/ssls_dp.sv
rtl/seven_segment_led_scan_controller.sv
rtl/ssls_checker.sv
tb/seven_segment_led_scan_controller_test.sv
